@@ src/nct_pkg.sv @@
`default_nettype none
package nct_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEF_TRACK_SLOTS = 64;
    localparam int DEF_ID_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MISS_BITS = 8;

    localparam logic [15:0] RST_FIRST_ID = 16'd0;
    localparam logic [11:0] RST_MAX_DIST = 12'd50;
    localparam logic [7:0] RST_MAX_UNDETECTED = 8'd10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FIRST_ID = 2'd0,
        CFG_MAX_DIST = 2'd1,
        CFG_MAX_UNDETECTED = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SRC_NEW_ID = 2'd0,
        SRC_PRIOR = 2'd1,
        SRC_LOST = 2'd2,
        SRC_FRAME_END = 2'd3
    } match_src_t;

    typedef struct packed {
        logic cmd;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } in_item_t;

    typedef struct packed {
        logic [15:0] object_id;
        logic [1:0] match_source;
        logic [6:0] remembered;
        logic overflow;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic begin_scan;
        logic sel_lost;
        logic stream;
        logic age;
        logic claim;
        logic new_id;
        logic store;
        logic flip;
        logic emit;
    } nct_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic frame_end;
        logic out_free;
    } nct_sts_t;

endpackage
`default_nettype wire

@@ src/nct_ram.sv @@
`default_nettype none
module nct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input wire logic aclk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ src/nct_ctrl.sv @@
`default_nettype none
module nct_ctrl import nct_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire nct_sts_t sts,
    output nct_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SCAN_PRI = 10'b0000000010,
        ST_SCAN_LST = 10'b0000000100,
        ST_CLAIM = 10'b0000001000,
        ST_NEWID = 10'b0000010000,
        ST_STORE = 10'b0000100000,
        ST_AGE_PRI = 10'b0001000000,
        ST_AGE_LST = 10'b0010000000,
        ST_FLIP = 10'b0100000000,
        ST_RESULT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.load = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.begin_scan = 1'b1;
                    state_next = sts.frame_end ? ST_AGE_PRI : ST_SCAN_PRI;
                end
            end
            ST_SCAN_PRI: begin
                cmd.stream = 1'b1;
                if (sts.done) begin
                    if (sts.hit) begin
                        state_next = ST_CLAIM;
                    end else begin
                        cmd.begin_scan = 1'b1;
                        cmd.sel_lost = 1'b1;
                        state_next = ST_SCAN_LST;
                    end
                end
            end
            ST_SCAN_LST: begin
                cmd.stream = 1'b1;
                cmd.sel_lost = 1'b1;
                if (sts.done) begin
                    state_next = sts.hit ? ST_CLAIM : ST_NEWID;
                end
            end
            ST_CLAIM: begin
                cmd.claim = 1'b1;
                state_next = ST_STORE;
            end
            ST_NEWID: begin
                cmd.new_id = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                state_next = ST_RESULT;
            end
            ST_AGE_PRI: begin
                cmd.stream = 1'b1;
                cmd.age = 1'b1;
                if (sts.done) begin
                    cmd.begin_scan = 1'b1;
                    cmd.sel_lost = 1'b1;
                    state_next = ST_AGE_LST;
                end
            end
            ST_AGE_LST: begin
                cmd.stream = 1'b1;
                cmd.age = 1'b1;
                cmd.sel_lost = 1'b1;
                if (sts.done) begin
                    state_next = ST_FLIP;
                end
            end
            ST_FLIP: begin
                cmd.flip = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ src/nct_dp.sv @@
`default_nettype none
module nct_dp import nct_pkg::*; #(
    parameter int TRACK_SLOTS = DEF_TRACK_SLOTS,
    parameter int ID_BITS = DEF_ID_BITS
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire in_item_t s_data,
    input wire logic cfg_we,
    input wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input wire nct_cmd_t cmd,
    output nct_sts_t sts,
    output logic m_valid,
    input wire logic m_ready,
    output out_item_t m_data
);

    localparam int IDXW = $clog2(TRACK_SLOTS);
    localparam int CNTW = $clog2(TRACK_SLOTS + 1);
    localparam int CXW = COORD_BITS + 1;
    localparam int DW = CXW + 1;
    localparam int D2W = 2 * DW;
    localparam int EW = 1 + ID_BITS + 2 * CXW + MISS_BITS;
    localparam logic [CNTW-1:0] SLOTS = CNTW'(TRACK_SLOTS);

    // configuration
    logic [11:0] max_dist_reg;
    logic [7:0] max_und_reg;
    logic [ID_BITS-1:0] next_id_reg;
    logic overflow_reg;

    // item and bookkeeping
    logic [CXW-1:0] cx_reg, cy_reg;
    logic pbank_reg, lbank_reg;
    logic [CNTW-1:0] cur_cnt_reg, pri_cnt_reg, lost_cnt_reg, age_n_reg;
    logic [ID_BITS-1:0] res_id_reg;
    logic [1:0] res_src_reg;

    // stream and scan pipeline
    logic [CNTW-1:0] addr_reg;
    logic tok_v_reg, tok_sel_reg;
    logic [IDXW-1:0] tok_addr_reg;
    logic d_v_reg, d_sel_reg;
    logic [IDXW-1:0] d_addr_reg;
    logic [ID_BITS-1:0] d_id_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic q_v_reg, q_sel_reg;
    logic [IDXW-1:0] q_addr_reg;
    logic [ID_BITS-1:0] q_id_reg;
    logic [D2W-1:0] d2_reg;
    logic [D2W-1:0] best_reg;
    logic hit_reg, hit_sel_reg;
    logic [IDXW-1:0] hit_addr_reg;
    logic [ID_BITS-1:0] hit_id_reg;

    logic out_v_reg;
    out_item_t out_reg;

    // memories
    logic [EW-1:0] trk_rd [2];
    logic [EW-1:0] lst_rd [2];
    logic [1:0] trk_we, lst_we;
    logic [IDXW-1:0] trk_waddr, lst_waddr;
    logic [EW-1:0] trk_wdata, lst_wdata;

    logic [EW-1:0] rd_e;
    logic e_valid;
    logic [ID_BITS-1:0] e_id;
    logic [CXW-1:0] e_cx, e_cy;
    logic [MISS_BITS-1:0] e_miss, miss_new;
    logic in_range, live, age_keep, age_wr;
    logic signed [2*DW-1:0] sqx, sqy;
    logic out_free;

    assign rd_e = tok_sel_reg ? lst_rd[lbank_reg] : trk_rd[pbank_reg];
    assign e_valid = rd_e[EW-1];
    assign e_id = rd_e[EW-2 -: ID_BITS];
    assign e_cx = rd_e[2*CXW+MISS_BITS-1 -: CXW];
    assign e_cy = rd_e[CXW+MISS_BITS-1 -: CXW];
    assign e_miss = rd_e[MISS_BITS-1:0];
    assign in_range = CNTW'(tok_addr_reg) < (tok_sel_reg ? lost_cnt_reg : pri_cnt_reg);
    assign live = tok_v_reg && in_range && e_valid;
    assign miss_new = e_miss + MISS_BITS'(1);
    assign age_keep = live && cmd.age && (miss_new < max_und_reg);
    assign age_wr = age_keep && (age_n_reg < SLOTS);

    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;

    assign trk_waddr = cmd.claim ? hit_addr_reg : cur_cnt_reg[IDXW-1:0];
    assign trk_wdata = cmd.claim ? '0 : {1'b1, res_id_reg, cx_reg, cy_reg, MISS_BITS'(0)};
    assign lst_waddr = cmd.claim ? hit_addr_reg : age_n_reg[IDXW-1:0];
    assign lst_wdata = cmd.claim ? '0 : {1'b1, e_id, e_cx, e_cy, miss_new};

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            trk_we[b] = (cmd.claim && !hit_sel_reg && (1'(b) == pbank_reg))
                || (cmd.store && (cur_cnt_reg < SLOTS) && (1'(b) != pbank_reg));
            lst_we[b] = (cmd.claim && hit_sel_reg && (1'(b) == lbank_reg))
                || (age_wr && (1'(b) != lbank_reg));
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        nct_ram #(.WIDTH(EW), .DEPTH(TRACK_SLOTS)) u_trk (
            .aclk(aclk), .we(trk_we[g]), .waddr(trk_waddr), .wdata(trk_wdata),
            .raddr(addr_reg[IDXW-1:0]), .rdata(trk_rd[g])
        );
        nct_ram #(.WIDTH(EW), .DEPTH(TRACK_SLOTS)) u_lst (
            .aclk(aclk), .we(lst_we[g]), .waddr(lst_waddr), .wdata(lst_wdata),
            .raddr(addr_reg[IDXW-1:0]), .rdata(lst_rd[g])
        );
    end

    assign out_free = !out_v_reg || m_ready;
    assign sts.done = (addr_reg == SLOTS) && !tok_v_reg && !d_v_reg && !q_v_reg;
    assign sts.hit = hit_reg;
    assign sts.frame_end = s_data.cmd;
    assign sts.out_free = out_free;
    assign m_valid = out_v_reg;
    assign m_data = out_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg <= RST_MAX_DIST;
            max_und_reg <= RST_MAX_UNDETECTED;
            next_id_reg <= ID_BITS'(32'(RST_FIRST_ID));
            overflow_reg <= 1'b0;
            pbank_reg <= 1'b0;
            lbank_reg <= 1'b0;
            cur_cnt_reg <= '0;
            pri_cnt_reg <= '0;
            lost_cnt_reg <= '0;
            age_n_reg <= '0;
            addr_reg <= SLOTS;
            tok_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            hit_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIRST_ID: begin
                        next_id_reg <= ID_BITS'(32'(cfg_wdata));
                    end
                    CFG_MAX_DIST: max_dist_reg <= cfg_wdata[11:0];
                    CFG_MAX_UNDETECTED: max_und_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.new_id) begin
                next_id_reg <= next_id_reg + ID_BITS'(1);
            end
            if (cmd.store) begin
                if (cur_cnt_reg < SLOTS) begin
                    cur_cnt_reg <= cur_cnt_reg + CNTW'(1);
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.load) begin
                age_n_reg <= '0;
            end else if (age_keep) begin
                if (age_n_reg < SLOTS) begin
                    age_n_reg <= age_n_reg + CNTW'(1);
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.flip) begin
                pbank_reg <= !pbank_reg;
                lbank_reg <= !lbank_reg;
                pri_cnt_reg <= cur_cnt_reg;
                cur_cnt_reg <= '0;
                lost_cnt_reg <= age_n_reg;
            end
            if (cmd.begin_scan) begin
                addr_reg <= '0;
                hit_reg <= 1'b0;
            end else if (cmd.stream && addr_reg < SLOTS) begin
                addr_reg <= addr_reg + CNTW'(1);
            end
            tok_v_reg <= cmd.stream && !cmd.begin_scan && (addr_reg < SLOTS);
            d_v_reg <= live && !cmd.age;
            q_v_reg <= d_v_reg;
            if (q_v_reg && d2_reg < best_reg) begin
                hit_reg <= 1'b1;
            end
            if (cmd.emit) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= CXW'(s_data.left) + CXW'(s_data.width >> 1);
            cy_reg <= CXW'(s_data.top) + CXW'(s_data.height >> 1);
        end
        tok_sel_reg <= cmd.sel_lost;
        tok_addr_reg <= addr_reg[IDXW-1:0];
        d_sel_reg <= tok_sel_reg;
        d_addr_reg <= tok_addr_reg;
        d_id_reg <= e_id;
        dx_reg <= $signed({1'b0, cx_reg}) - $signed({1'b0, e_cx});
        dy_reg <= $signed({1'b0, cy_reg}) - $signed({1'b0, e_cy});
        q_sel_reg <= d_sel_reg;
        q_addr_reg <= d_addr_reg;
        q_id_reg <= d_id_reg;
        d2_reg <= D2W'($unsigned(sqx)) + D2W'($unsigned(sqy));
        if (cmd.begin_scan) begin
            best_reg <= D2W'(max_dist_reg) * D2W'(max_dist_reg);
        end else if (q_v_reg && d2_reg < best_reg) begin
            best_reg <= d2_reg;
            hit_sel_reg <= q_sel_reg;
            hit_addr_reg <= q_addr_reg;
            hit_id_reg <= q_id_reg;
        end
        if (cmd.claim) begin
            res_id_reg <= hit_id_reg;
            res_src_reg <= hit_sel_reg ? SRC_LOST : SRC_PRIOR;
        end else if (cmd.new_id) begin
            res_id_reg <= next_id_reg;
            res_src_reg <= SRC_NEW_ID;
        end else if (cmd.flip) begin
            res_id_reg <= '0;
            res_src_reg <= SRC_FRAME_END;
        end
        if (cmd.emit) begin
            out_reg.object_id <= 16'(res_id_reg);
            out_reg.match_source <= res_src_reg;
            out_reg.remembered <= (res_src_reg == SRC_FRAME_END) ? 7'(lost_cnt_reg) : 7'd0;
            out_reg.overflow <= overflow_reg;
        end
    end

endmodule
`default_nettype wire

@@ src/nearest_centroid_id_tracker.sv @@
`default_nettype none
// Nearest-centroid id tracker. A detection item takes its box centre and scans the
// previous frame's tracks, then the lost-track memory, one table entry per cycle from
// a single read port, keeping the first strictly nearest entry inside max_dist; the
// winner's id is reused, otherwise a fresh id is issued. The lost-track scan is skipped
// when the previous frame already matches. A frame-end item ages both tables into the
// other lost bank. One result per item; the overflow flag is sticky until reset.
module nearest_centroid_id_tracker import nct_pkg::*; #(
    parameter int TRACK_SLOTS = DEF_TRACK_SLOTS,
    parameter int ID_BITS = DEF_ID_BITS
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire in_item_t s_data,
    output logic m_valid,
    input wire logic m_ready,
    output out_item_t m_data,
    input wire logic cfg_we,
    input wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    nct_cmd_t cmd;
    nct_sts_t sts;

    nct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    nct_dp #(.TRACK_SLOTS(TRACK_SLOTS), .ID_BITS(ID_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .cmd(cmd), .sts(sts), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
module tb;
    import nct_pkg::*;

    typedef struct {
        bit v;
        bit [15:0] id;
        int cx;
        int cy;
        int miss;
    } trk_t;

    class track_book;
        trk_t prior[64];
        trk_t cur[64];
        trk_t lost[64];
        int cur_n;
        int lost_n;
        bit [15:0] id_ctr;
        bit ovf;
        bit [15:0] first;
        bit [11:0] mdist;
        bit [7:0] mund;
        out_item_t due[$];
        int errs;

        function new();
            trk_t z;
            z = '{default: 0};
            foreach (prior[i]) begin
                prior[i] = z;
                cur[i] = z;
                lost[i] = z;
            end
            cur_n = 0;
            lost_n = 0;
            first = RST_FIRST_ID;
            mdist = RST_MAX_DIST;
            mund = RST_MAX_UNDETECTED;
            id_ctr = first;
            ovf = 0;
            errs = 0;
        endfunction

        function void write_reg(cfg_index_t idx, bit [15:0] v);
            case (idx)
                CFG_FIRST_ID: begin
                    first = v;
                    id_ctr = v;
                end
                CFG_MAX_DIST: mdist = v[11:0];
                CFG_MAX_UNDETECTED: mund = v[7:0];
                default: ;
            endcase
        endfunction

        function int nearest(bit in_lost, int cx, int cy);
            longint best;
            longint d2;
            longint dx;
            longint dy;
            int hit;
            trk_t e;
            best = longint'(mdist) * longint'(mdist);
            hit = -1;
            for (int i = 0; i < 64; i++) begin
                e = in_lost ? lost[i] : prior[i];
                if (e.v) begin
                    dx = cx - e.cx;
                    dy = cy - e.cy;
                    d2 = dx * dx + dy * dy;
                    if (d2 < best) begin
                        best = d2;
                        hit = i;
                    end
                end
            end
            return hit;
        endfunction

        function void note_input(in_item_t x);
            out_item_t r;
            trk_t aged[64];
            trk_t e;
            int cx;
            int cy;
            int k;
            int n;
            int m;
            bit [15:0] id;
            match_src_t src;
            if (x.cmd == 1'b0) begin
                cx = x.left + (x.width >> 1);
                cy = x.top + (x.height >> 1);
                k = nearest(0, cx, cy);
                if (k >= 0) begin
                    id = prior[k].id;
                    prior[k].v = 0;
                    src = SRC_PRIOR;
                end else begin
                    k = nearest(1, cx, cy);
                    if (k >= 0) begin
                        id = lost[k].id;
                        lost[k].v = 0;
                        src = SRC_LOST;
                    end else begin
                        id = id_ctr;
                        id_ctr = id_ctr + 16'd1;
                        src = SRC_NEW_ID;
                    end
                end
                if (cur_n < 64) begin
                    cur[cur_n] = '{1'b1, id, cx, cy, 0};
                    cur_n++;
                end else begin
                    ovf = 1;
                end
                r.object_id = id;
                r.match_source = src;
                r.remembered = 7'd0;
            end else begin
                n = 0;
                foreach (aged[i]) aged[i] = '{default: 0};
                for (int i = 0; i < 128; i++) begin
                    e = (i < 64) ? prior[i] : lost[i - 64];
                    if (e.v) begin
                        m = (e.miss + 1) & 8'hFF;
                        if (m < mund) begin
                            if (n < 64) begin
                                aged[n] = e;
                                aged[n].miss = m;
                                n++;
                            end else begin
                                ovf = 1;
                            end
                        end
                    end
                end
                lost = aged;
                lost_n = n;
                prior = cur;
                foreach (cur[i]) cur[i] = '{default: 0};
                cur_n = 0;
                r.object_id = 16'd0;
                r.match_source = SRC_FRAME_END;
                r.remembered = n[6:0];
            end
            r.overflow = ovf;
            due = {due, r};
        endfunction

        function void check_result(out_item_t y);
            out_item_t w;
            if (due.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected transfer: %p", y);
                return;
            end
            w = due.pop_front();
            if (y.object_id !== w.object_id || y.match_source !== w.match_source ||
                y.remembered !== w.remembered || y.overflow !== w.overflow) begin
                errs++;
                if (errs <= 10)
                    $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        w.object_id, w.match_source, w.remembered, w.overflow,
                        y.object_id, y.match_source, y.remembered, y.overflow);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    track_book sb;
    bit quiet;
    bit hold_req;
    bit held;
    int sent;
    int objs_l[$];
    int objs_t[$];
    int objs_w[$];
    int objs_h[$];

    nearest_centroid_id_tracker uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (700) @(negedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic send(in_item_t it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_valid <= 0;
            repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic box(int l, int t, int w, int h);
        in_item_t it;
        it.cmd = 1'b0;
        it.left = COORD_BITS'(l);
        it.top = COORD_BITS'(t);
        it.width = COORD_BITS'(w);
        it.height = COORD_BITS'(h);
        send(it);
    endtask

    task automatic frame_end();
        in_item_t it;
        it.cmd = 1'b1;
        it.left = COORD_BITS'($urandom);
        it.top = COORD_BITS'($urandom);
        it.width = COORD_BITS'($urandom);
        it.height = COORD_BITS'($urandom);
        send(it);
    endtask

    task automatic drain();
        int n;
        @(negedge aclk);
        s_valid <= 0;
        n = 0;
        while (sb.due.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_index_t idx, bit [15:0] v);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    function automatic int jit(int v);
        int r;
        r = v + $urandom_range(0, 16) - 8;
        if (r < 0) r = 0;
        if (r > 4095) r = 4095;
        return r;
    endfunction

    // one frame of tracked objects with some new, dropped and noise boxes
    task automatic random_frame();
        int n;
        int nl;
        int nt;
        int nw;
        int nh;
        for (int i = 0; i < objs_l.size(); i++) begin
            if ($urandom_range(0, 9) < 8) begin
                objs_l[i] = jit(objs_l[i]);
                objs_t[i] = jit(objs_t[i]);
                box(objs_l[i], objs_t[i], objs_w[i], objs_h[i]);
            end
        end
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            if (objs_l.size() < 12) begin
                nl = $urandom_range(0, 4095);
                nt = $urandom_range(0, 4095);
                nw = $urandom_range(0, 4095);
                nh = $urandom_range(0, 4095);
                objs_l = {objs_l, nl};
                objs_t = {objs_t, nt};
                objs_w = {objs_w, nw};
                objs_h = {objs_h, nh};
                box(nl, nt, nw, nh);
            end
        end
        if (objs_l.size() > 0 && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(0, objs_l.size() - 1);
            objs_l.delete(n);
            objs_t.delete(n);
            objs_w.delete(n);
            objs_h.delete(n);
        end
        if ($urandom_range(0, 9) == 0)
            box($urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 4095));
        frame_end();
    endtask

    initial begin
        bit [11:0] dists[4] = '{12'd50, 12'd4095, 12'd300, 12'd20};
        bit [7:0] unds[4] = '{8'd10, 8'd255, 8'd3, 8'd1};
        sb = new();
        quiet = 0;
        hold_req = 0;
        held = 0;
        sent = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_we = 0;
        cfg_index = CFG_FIRST_ID;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // extremes, prior match, lost match
        box(0, 0, 0, 0);
        box(4095, 4095, 4095, 4095);
        box(100, 100, 40, 40);
        frame_end();
        box(0, 0, 1, 1);
        box(4095, 4095, 4095, 4095);
        frame_end();
        frame_end();
        box(4095, 4095, 4095, 4094);
        box(103, 101, 40, 40);
        frame_end();
        drain();
        set_reg(CFG_FIRST_ID, 16'hFFFF);
        set_reg(CFG_MAX_DIST, 16'd0);
        set_reg(CFG_MAX_UNDETECTED, 16'd0);
        box(0, 0, 0, 0);
        box(0, 0, 0, 0);
        frame_end();
        box(0, 0, 0, 0);
        frame_end();
        drain();
        set_reg(CFG_MAX_DIST, 16'd4095);
        set_reg(CFG_MAX_UNDETECTED, 16'd1);
        box(2000, 2000, 10, 10);
        frame_end();
        box(0, 0, 0, 0);
        frame_end();
        frame_end();
        drain();

        for (int p = 0; p < 4; p++) begin
            set_reg(CFG_FIRST_ID, 16'($urandom));
            set_reg(CFG_MAX_DIST, 16'(dists[p]));
            set_reg(CFG_MAX_UNDETECTED, 16'(unds[p]));
            objs_l.delete();
            objs_t.delete();
            objs_w.delete();
            objs_h.delete();
            while (sent < 30 + (p + 1) * 400) begin
                if (p == 1 && !held && sent >= 30 + 400 + 200) begin
                    hold_req = 1;
                    held = 1;
                end
                random_frame();
            end
            drain();
        end

        // table overflow, last and without idling
        quiet = 1;
        set_reg(CFG_MAX_DIST, 16'd0);
        set_reg(CFG_MAX_UNDETECTED, 16'd255);
        for (int f = 0; f < 3; f++) begin
            for (int i = 0; i < (f == 0 ? 66 : 64); i++)
                box($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
            frame_end();
        end
        frame_end();
        drain();

        if (sb.errs == 0 && sb.due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
